[rtl/bsed_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bsed_pkg;

    // Results one input byte can cause
    localparam int RES_MAX = 3;
    localparam int CNT_W   = 2;

    // Decoder modes
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_BSLASH = 3'd1,
        MODE_OCT    = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_MUTE   = 3'd4
    } t_mode;

    // Digit limits of the numeric escapes
    localparam logic [CNT_W-1:0] OCT_MAX_DIGITS = 2'd3;
    localparam logic [CNT_W-1:0] HEX_MAX_DIGITS = 2'd2;

    // Characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_C   = 8'h63;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_V   = 8'h76;
    localparam logic [7:0] CH_LO_X   = 8'h78;

    // Control codes produced by the escapes
    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_HT  = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    typedef logic [RES_MAX-1:0][7:0] t_bytes;

    // Decoded bytes of one input item, first byte in entry 0
    typedef struct packed {
        t_bytes            bytes;
        logic [CNT_W-1:0]  count;
    } t_result;

    // Append one byte to a result list, drop it when the list is full
    function automatic t_result f_push(t_result r, logic [7:0] b);
        t_result q;
        q = r;
        if (r.count != CNT_W'(RES_MAX)) begin
            q.bytes[r.count] = b;
            q.count          = r.count + 2'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

[rtl/bsed_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Raw text channel
interface bsed_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

// Decoded text channel
interface bsed_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_end;

    modport source (output valid, output out_byte, output run_end, input ready);
    modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

`default_nettype wire

[rtl/backslash_escape_decoder_top.sv]
// Backslash escape decoder.
// Input channel i_in carries one raw text byte per transfer with an
// end_of_message flag on the last byte of a message. Output channel o_out
// carries decoded bytes; run_end marks the last byte caused by one input
// byte. An input byte may cause zero to three output bytes.
// The decoded bytes of an item are registered into the result register, or
// into the holding register while the result register is still busy.
// Throughput: one input byte per cycle while each byte yields at most one
// output byte and the receiver takes every byte; the single output port
// drains the result register one byte per cycle while the receiver is ready.
// A holding register behind the result register takes the next decoded
// item while the result register drains, so i_in.ready drops only when
// both are full; nothing is lost or reordered under stall.
// Reset (synchronous, active low) returns the decoder to plain-text mode,
// clears any pending escape and discards undelivered bytes.
`timescale 1ns / 1ps
`default_nettype none

module backslash_escape_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsed_in_if.sink     i_in,
    bsed_out_if.source  o_out
);
    import bsed_pkg::*;

    t_result          w_dec;
    logic             w_in_fire;
    logic             w_out_fire;
    logic             w_ser_done;
    logic             w_dec_push;

    t_bytes           r_bytes;
    logic [CNT_W-1:0] r_left;
    logic [CNT_W-1:0] r_idx;
    t_result          r_hold;
    logic             r_hold_v;
    t_bytes           n_bytes;
    logic [CNT_W-1:0] n_left;
    logic [CNT_W-1:0] n_idx;
    t_result          n_hold;
    logic             n_hold_v;

    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_fire = o_out.valid && o_out.ready;
    assign w_ser_done = (r_left == '0) || ((r_left == 2'd1) && w_out_fire);
    assign w_dec_push = w_in_fire && (w_dec.count != '0);

    bsed_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_in_fire),
        .i_byte  (i_in.in_byte),
        .i_eom   (i_in.end_of_message),
        .o_res   (w_dec)
    );

    // Load the result register from the holding slot or the decoder, step through its bytes and fill the holding slot
    always_comb begin
        n_bytes  = r_bytes;
        n_left   = r_left;
        n_idx    = r_idx;
        n_hold   = r_hold;
        n_hold_v = r_hold_v;
        if (w_ser_done) begin
            n_idx = '0;
            if (r_hold_v) begin
                n_bytes  = r_hold.bytes;
                n_left   = r_hold.count;
                n_hold_v = 1'b0;
            end else if (w_dec_push) begin
                n_bytes = w_dec.bytes;
                n_left  = w_dec.count;
            end else begin
                n_left = '0;
            end
        end else begin
            if (w_out_fire) begin
                n_left = r_left - 2'd1;
                n_idx  = r_idx + 2'd1;
            end
            if (w_dec_push) begin
                n_hold   = w_dec;
                n_hold_v = 1'b1;
            end
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_idx    <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_idx    <= n_idx;
            r_hold_v <= n_hold_v;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_hold  <= n_hold;
    end

    assign i_in.ready     = !r_hold_v;
    assign o_out.valid    = (r_left != '0);
    assign o_out.out_byte = r_bytes[r_idx];
    assign o_out.run_end  = (r_left == 2'd1);

endmodule

`default_nettype wire

[rtl/bsed_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsed_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_eom,
    output bsed_pkg::t_result  o_res
);
    import bsed_pkg::*;

    t_mode            r_mode;
    logic [CNT_W-1:0] r_seen;
    logic [7:0]       r_acc;
    t_mode            n_mode;
    logic [CNT_W-1:0] n_seen;
    logic [7:0]       n_acc;
    t_result          n_res;

    logic             w_hex_mode;
    logic             w_oct_ok;
    logic             w_dig_ok;
    logic             w_hex_ok;
    logic             w_hex_let;
    logic [3:0]       w_hex_val;
    logic [7:0]       w_acc_calc;
    logic [CNT_W-1:0] w_seen_inc;
    logic             w_full;
    logic [7:0]       w_letter;

    // Classify the byte as a digit of the active numeric escape
    assign w_hex_mode = (r_mode == MODE_HEX);
    assign w_oct_ok   = (i_byte >= CH_ZERO) && (i_byte <= CH_SEVEN);
    assign w_hex_let  = ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_F))
                     || ((i_byte >= CH_LO_A) && (i_byte <= CH_LO_F));
    assign w_hex_ok   = ((i_byte >= CH_ZERO) && (i_byte <= CH_NINE)) || w_hex_let;
    assign w_hex_val  = w_hex_let ? (i_byte[3:0] + 4'd9) : i_byte[3:0];
    assign w_dig_ok   = w_hex_mode ? w_hex_ok : w_oct_ok;

    // Shift the digit into the accumulator, keep 8 bits
    assign w_acc_calc = w_hex_mode ? {r_acc[3:0], w_hex_val} : {r_acc[4:0], i_byte[2:0]};
    assign w_seen_inc = r_seen + 2'd1;
    assign w_full     = w_hex_mode ? (w_seen_inc == HEX_MAX_DIGITS)
                                   : (w_seen_inc == OCT_MAX_DIGITS);
    assign w_letter   = w_hex_mode ? CH_LO_X : CH_ZERO;

    // Decode one byte against the current mode
    always_comb begin
        n_res  = '0;
        n_mode = r_mode;
        n_seen = r_seen;
        n_acc  = r_acc;

        unique case (r_mode)
            MODE_BSLASH: begin
                n_mode = MODE_IDLE;
                n_seen = '0;
                n_acc  = '0;
                unique case (i_byte)
                    CH_BSLASH: n_res  = f_push(n_res, CH_BSLASH);
                    CH_LO_A:   n_res  = f_push(n_res, CODE_BEL);
                    CH_LO_B:   n_res  = f_push(n_res, CODE_BS);
                    CH_LO_E:   n_res  = f_push(n_res, CODE_ESC);
                    CH_LO_F:   n_res  = f_push(n_res, CODE_FF);
                    CH_LO_N:   n_res  = f_push(n_res, CODE_LF);
                    CH_LO_R:   n_res  = f_push(n_res, CODE_CR);
                    CH_LO_T:   n_res  = f_push(n_res, CODE_HT);
                    CH_LO_V:   n_res  = f_push(n_res, CODE_VT);
                    CH_LO_C:   n_mode = MODE_MUTE;
                    CH_ZERO:   n_mode = MODE_OCT;
                    CH_LO_X:   n_mode = MODE_HEX;
                    default: begin
                        n_res = f_push(n_res, CH_BSLASH);
                        n_res = f_push(n_res, i_byte);
                    end
                endcase
            end
            MODE_OCT, MODE_HEX: begin
                if (w_dig_ok) begin
                    n_acc  = w_acc_calc;
                    n_seen = w_seen_inc;
                    if (w_full) begin
                        n_res  = f_push(n_res, w_acc_calc);
                        n_mode = MODE_IDLE;
                        n_seen = '0;
                        n_acc  = '0;
                    end
                end else begin
                    // Close the escape, then take the byte as plain text
                    if (r_seen == '0) begin
                        n_res = f_push(n_res, CH_BSLASH);
                        n_res = f_push(n_res, w_letter);
                    end else begin
                        n_res = f_push(n_res, r_acc);
                    end
                    n_seen = '0;
                    n_acc  = '0;
                    if (i_byte == CH_BSLASH) begin
                        n_mode = MODE_BSLASH;
                    end else begin
                        n_mode = MODE_IDLE;
                        n_res  = f_push(n_res, i_byte);
                    end
                end
            end
            MODE_MUTE: begin
                n_mode = MODE_MUTE;
            end
            default: begin
                if (i_byte == CH_BSLASH) begin
                    n_mode = MODE_BSLASH;
                end else begin
                    n_mode = MODE_IDLE;
                    n_res  = f_push(n_res, i_byte);
                end
            end
        endcase

        // Flush a pending escape at the end of the message and clear state
        if (i_eom) begin
            if (n_mode == MODE_BSLASH) begin
                n_res = f_push(n_res, CH_BSLASH);
            end else if ((n_mode == MODE_OCT) || (n_mode == MODE_HEX)) begin
                if (n_seen == '0) begin
                    n_res = f_push(n_res, CH_BSLASH);
                    n_res = f_push(n_res, (n_mode == MODE_HEX) ? CH_LO_X : CH_ZERO);
                end else begin
                    n_res = f_push(n_res, n_acc);
                end
            end
            n_mode = MODE_IDLE;
            n_seen = '0;
            n_acc  = '0;
        end
    end

    assign o_res = n_res;

    // Hold decoder state, advance on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_seen <= '0;
            r_acc  <= '0;
        end else if (i_fire) begin
            r_mode <= n_mode;
            r_seen <= n_seen;
            r_acc  <= n_acc;
        end
    end

endmodule

`default_nettype wire

[rtl/bsed_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module bsed_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_ready,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_run_end
);

    // Hold output valid while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped during stall");

    // Hold output payload while the receiver stalls
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_out_byte) && $stable(i_out_run_end)))
        else $error("output payload changed during stall");

    // Drop all pending output after reset
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Back-pressure input only while output bytes are pending
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output pending");

    // While the output stalls with the holding slot full, the input stays closed to a third item
    a_no_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready && !i_in_ready) |=> !i_in_ready)
        else $error("input reopened while output stalled with a full slot");

endmodule

bind backslash_escape_decoder_top bsed_checker u_bsed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_byte    (o_out.out_byte),
    .i_out_run_end (o_out.run_end)
);

`default_nettype wire

[dv/tb_backslash_escape_decoder_top.sv]
`timescale 1ns / 1ps

module tb_backslash_escape_decoder_top;
    import bsed_pkg::*;

    localparam int RANDOM_ITEMS   = 420;
    localparam int HOLD_AT        = 150;   // accepted items before the long receiver hold
    localparam int LONG_HOLD      = 80;
    localparam int DRAIN_AT       = 300;   // sent items before the sender waits for a drain
    localparam int CALM_FROM      = 200;   // sender runs without gaps in this window
    localparam int CALM_TO        = 260;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } t_raw;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    logic i_clk;
    logic i_rst_n;

    bsed_in_if  u_in ();
    bsed_out_if u_out ();

    backslash_escape_decoder_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    // Raw bytes waiting to be sent, decoded bytes waiting to arrive
    t_raw       raw_q[$];
    t_decoded   decoded_q[$];
    logic [7:0] step_bytes[$];

    // Decoder state as predicted
    t_mode      dec_mode;
    logic [1:0] dec_digits;
    logic [7:0] dec_acc;

    int   mismatch_count;
    int   total_items;
    int   items_sent;
    int   items_accepted;
    int   idle_cycles;
    bit   in_taken;
    int   burst_left;
    int   gap_left;
    bit   drain_wait;
    int   hold_left;
    bit   hold_done;
    int   rx_mode;
    int   rx_tick;
    t_raw     next_raw;
    t_decoded head;

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Decoder prediction
    // ------------------------------------------------------------------

    task automatic emit_byte(input logic [7:0] b);
        if (step_bytes.size() < RES_MAX) step_bytes.push_back(b);
    endtask

    task automatic clear_escape();
        dec_mode   = MODE_IDLE;
        dec_digits = '0;
        dec_acc    = '0;
    endtask

    task automatic plain_char(input logic [7:0] b);
        if (b == CH_BSLASH) begin
            dec_mode = MODE_BSLASH;
        end else begin
            dec_mode = MODE_IDLE;
            emit_byte(b);
        end
    endtask

    // Emit the value, or the escape literally when no digit came
    task automatic flush_numeric(input logic [7:0] letter);
        if (dec_digits == 0) begin
            emit_byte(CH_BSLASH);
            emit_byte(letter);
        end else begin
            emit_byte(dec_acc);
        end
        clear_escape();
    endtask

    task automatic resolve_escape(input logic [7:0] b);
        clear_escape();
        case (b)
            CH_BSLASH: emit_byte(CH_BSLASH);
            CH_LO_A:   emit_byte(CODE_BEL);
            CH_LO_B:   emit_byte(CODE_BS);
            CH_LO_E:   emit_byte(CODE_ESC);
            CH_LO_F:   emit_byte(CODE_FF);
            CH_LO_N:   emit_byte(CODE_LF);
            CH_LO_R:   emit_byte(CODE_CR);
            CH_LO_T:   emit_byte(CODE_HT);
            CH_LO_V:   emit_byte(CODE_VT);
            CH_LO_C:   dec_mode = MODE_MUTE;
            CH_ZERO:   dec_mode = MODE_OCT;
            CH_LO_X:   dec_mode = MODE_HEX;
            default: begin
                emit_byte(CH_BSLASH);
                emit_byte(b);
            end
        endcase
    endtask

    task automatic numeric_digit(input logic [7:0] b, input bit hex);
        int         d;
        int         acc_next;
        logic [1:0] max_digits;
        max_digits = hex ? HEX_MAX_DIGITS : OCT_MAX_DIGITS;
        d = -1;
        if (b >= CH_ZERO && b <= (hex ? CH_NINE : CH_SEVEN))
            d = int'(b) - int'(CH_ZERO);
        else if (hex && b >= CH_UP_A && b <= CH_UP_F)
            d = int'(b) - int'(CH_UP_A) + 10;
        else if (hex && b >= CH_LO_A && b <= CH_LO_F)
            d = int'(b) - int'(CH_LO_A) + 10;
        if (d >= 0) begin
            // Keep the value to 8 bits; three octal digits may overflow
            acc_next   = int'(dec_acc) * (hex ? 16 : 8) + d;
            dec_acc    = acc_next[7:0];
            dec_digits = dec_digits + 2'd1;
            if (dec_digits >= max_digits) begin
                emit_byte(dec_acc);
                clear_escape();
            end
        end else begin
            flush_numeric(hex ? CH_LO_X : CH_ZERO);
            plain_char(b);
        end
    endtask

    // Advance the decoder by one raw byte and queue the bytes it yields
    task automatic decode_byte(input logic [7:0] b, input logic eom);
        step_bytes.delete();
        case (dec_mode)
            MODE_BSLASH: resolve_escape(b);
            MODE_OCT:    numeric_digit(b, 1'b0);
            MODE_HEX:    numeric_digit(b, 1'b1);
            MODE_MUTE:   ;
            default:     plain_char(b);
        endcase
        if (eom) begin
            case (dec_mode)
                MODE_BSLASH: emit_byte(CH_BSLASH);
                MODE_OCT:    flush_numeric(CH_ZERO);
                MODE_HEX:    flush_numeric(CH_LO_X);
                default:     ;
            endcase
            clear_escape();
        end
        foreach (step_bytes[i])
            decoded_q.push_back('{data: step_bytes[i], last: (i == step_bytes.size() - 1)});
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    task automatic push_text(input string s, input bit eom);
        for (int i = 0; i < s.len(); i++)
            raw_q.push_back('{data: s[i], eom: eom && (i == s.len() - 1)});
    endtask

    // Build one message from random tokens; return the bytes not silenced
    task automatic add_message(output int live);
        logic [7:0] msg[$];
        string      hex_chars;
        int         ntok;
        int         kind;
        int         mute_start;
        logic [7:0] b;
        hex_chars  = "0123456789abcdefABCDEF";
        mute_start = -1;
        ntok       = $urandom_range(1, 8);
        for (int t = 0; t < ntok; t++) begin
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                b = 8'($urandom_range(32, 126));
                msg.push_back((b == CH_BSLASH) ? CH_UP_A : b);
            end else if (kind < 55) begin
                msg.push_back(CH_BSLASH);
                case ($urandom_range(0, 8))
                    0: msg.push_back(CH_BSLASH);
                    1: msg.push_back(CH_LO_A);
                    2: msg.push_back(CH_LO_B);
                    3: msg.push_back(CH_LO_E);
                    4: msg.push_back(CH_LO_F);
                    5: msg.push_back(CH_LO_N);
                    6: msg.push_back(CH_LO_R);
                    7: msg.push_back(CH_LO_T);
                    default: msg.push_back(CH_LO_V);
                endcase
            end else if (kind < 70) begin
                msg.push_back(CH_BSLASH);
                msg.push_back(CH_ZERO);
                repeat ($urandom_range(0, 3))
                    msg.push_back(8'(CH_ZERO + 8'($urandom_range(0, 7))));
            end else if (kind < 85) begin
                msg.push_back(CH_BSLASH);
                msg.push_back(CH_LO_X);
                repeat ($urandom_range(0, 2)) msg.push_back(hex_chars[$urandom_range(0, 21)]);
            end else if (kind < 90) begin
                // Unknown escape byte
                do b = 8'($urandom_range(0, 255));
                while (b inside {CH_BSLASH, CH_LO_A, CH_LO_B, CH_LO_C, CH_LO_E, CH_LO_F,
                                 CH_LO_N, CH_LO_R, CH_LO_T, CH_LO_V, CH_ZERO, CH_LO_X});
                msg.push_back(CH_BSLASH);
                msg.push_back(b);
            end else if (kind < 93) begin
                msg.push_back(CH_BSLASH);
                msg.push_back(CH_LO_C);
                if (mute_start < 0) mute_start = msg.size();
            end else begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
        // Leave a lone backslash pending at the end now and then
        if ($urandom_range(0, 9) == 0) msg.push_back(CH_BSLASH);
        live = (mute_start < 0) ? msg.size() : mute_start;
        foreach (msg[i]) raw_q.push_back('{data: msg[i], eom: (i == msg.size() - 1)});
    endtask

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int exp_v, input int got_v);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, exp_v, got_v);
        mismatch_count++;
    endtask

    // Check output transfers, predict on input transfers, watch for hangs
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (u_out.valid && u_out.ready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected byte", 0, int'(u_out.out_byte));
                end else begin
                    head = decoded_q.pop_front();
                    if (u_out.out_byte !== head.data)
                        report_mismatch("out_byte", int'(head.data), int'(u_out.out_byte));
                    if (u_out.run_end !== head.last)
                        report_mismatch("run_end", int'(head.last), int'(u_out.run_end));
                end
            end
            if (u_in.valid && u_in.ready) begin
                decode_byte(u_in.in_byte, u_in.end_of_message);
                in_taken = 1'b1;
                items_accepted++;
            end
            if ((u_out.valid && u_out.ready) || (u_in.valid && u_in.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender: bursts with gaps, one drain pause
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            u_in.valid <= 1'b0;
        end else if (u_in.valid && !in_taken) begin
            // hold the offered byte until it is taken
        end else begin
            in_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                u_in.valid <= 1'b0;
            end else if (drain_wait) begin
                if (decoded_q.size() == 0) drain_wait = 1'b0;
                u_in.valid <= 1'b0;
            end else if (raw_q.size() > 0) begin
                next_raw = raw_q.pop_front();
                u_in.valid          <= 1'b1;
                u_in.in_byte        <= next_raw.data;
                u_in.end_of_message <= next_raw.eom;
                items_sent++;
                if (items_sent == DRAIN_AT) drain_wait = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 20);
                    if (items_sent >= CALM_FROM && items_sent < CALM_TO)
                        gap_left = 0;
                    else
                        gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                u_in.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changing stall pattern, one long hold
    // ------------------------------------------------------------------

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            u_out.ready <= 1'b0;
        end else if (!hold_done && items_accepted >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            u_out.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0:       u_out.ready <= 1'b1;
                1:       u_out.ready <= ($urandom_range(0, 1) == 1);
                2:       u_out.ready <= ($urandom_range(0, 3) == 0);
                default: u_out.ready <= ((rx_tick % 3) != 2);
            endcase
            rx_tick++;
            if ((rx_tick % 50) == 0) rx_mode = $urandom_range(0, 3);
        end
    end

    // ------------------------------------------------------------------
    // Sequence: reset, stimulus, drain, verdict
    // ------------------------------------------------------------------

    initial begin
        int live;
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        u_in.valid          = 1'b0;
        u_in.in_byte        = '0;
        u_in.end_of_message = 1'b0;
        u_out.ready         = 1'b0;
        mismatch_count      = 0;
        items_sent          = 0;
        items_accepted      = 0;
        idle_cycles         = 0;
        in_taken            = 1'b0;
        burst_left          = 4;
        gap_left            = 0;
        drain_wait          = 1'b0;
        hold_left           = 0;
        hold_done           = 1'b0;
        rx_mode             = 0;
        rx_tick             = 0;
        dec_mode            = MODE_IDLE;
        dec_digits          = '0;
        dec_acc             = '0;

        // Zero byte and all-ones byte, then a lone backslash at message end
        raw_q.push_back('{data: 8'h00, eom: 1'b0});
        raw_q.push_back('{data: 8'hFF, eom: 1'b0});
        push_text("\\", 1'b1);
        // Unknown escape, then two hex digits of both cases
        push_text("\\q\\xFf", 1'b1);
        // Three octal digits that overflow 8 bits
        push_text("\\0777", 1'b1);
        // Hex escape with no digits, ended by a new escape
        push_text("\\x\\n", 1'b1);
        // Octal escape ended by a non-digit
        push_text("\\05z", 1'b1);
        // Silenced until the end of the message
        push_text("\\cAB", 1'b1);
        // Numeric escape pending at message end
        push_text("\\01", 1'b1);

        // Fill up to the item budget with random messages
        while (raw_q.size() < RANDOM_ITEMS) add_message(live);
        total_items = raw_q.size();

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (items_accepted != total_items || decoded_q.size() != 0);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/bsed_pkg.sv
rtl/bsed_if.sv
rtl/bsed_core.sv
rtl/backslash_escape_decoder_top.sv
rtl/bsed_checker.sv
dv/tb_backslash_escape_decoder_top.sv
